/* rtl/core/acc_pkg.sv */
// Shared constants, types and helpers of the altitude cascade controller.
// No dependencies; every other file of the block refers to it by scope.
package acc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COUNT_WIDTH = 16;

  localparam int DATA_W     = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int WIDE_W     = 64;
  localparam int MODE_W     = 3;
  localparam int THR_W      = 10;
  // integral tops out at 600 in Q format, plus sign
  localparam int INTEG_W    = FRAC_BITS + 11;
  // ramp limit is 500 * tick_period
  localparam int LIM_W      = CFG_W + 9;

  // shared unit: multiply one bit a cycle, divide DIV_BITS bits a cycle
  localparam int DIV_BITS   = 4;
  localparam int DIV_W      = 5;
  localparam int MUL_STEPS  = CFG_W;
  localparam int DIV_STEPS  = WIDE_W / DIV_BITS;
  localparam int MAX_STEPS  = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
  localparam int STEP_CNT_W = $clog2(MAX_STEPS + 1);
  localparam int CMP_W      = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam wide_t ONE_Q        = wide_t'(1) << FRAC_BITS;
  localparam wide_t INTEG_MAX    = wide_t'(600) << FRAC_BITS;
  localparam wide_t THR_MAX      = wide_t'(900) << FRAC_BITS;
  localparam wide_t TAKEOFF_DONE = wide_t'(4) << FRAC_BITS;   // 5*h >= 4
  localparam wide_t LANDED       = wide_t'(3) << FRAC_BITS;   // 20*h <= 3
  localparam logic [THR_W-1:0] THR_MAX_INT = THR_W'(900);

  localparam data_t VEL_TAKEOFF = data_t'(60) << FRAC_BITS;
  localparam data_t VEL_LANDING = -(data_t'(45) << FRAC_BITS);
  localparam data_t HOLD_HEIGHT = data_t'(1) << FRAC_BITS;

  localparam logic [DIV_W-1:0] DIV_FIVE   = DIV_W'(5);
  localparam logic [DIV_W-1:0] DIV_TWENTY = DIV_W'(20);

  localparam logic [CFG_W-1:0] TICK_PERIOD_RST = CFG_W'(1311);
  localparam logic [CFG_W-1:0] GROUND_WAIT_RST = CFG_W'(100);
  localparam logic [CFG_W-1:0] READY_WAIT_RST  = CFG_W'(100);
  localparam logic [CFG_W-1:0] HOVER_RST       = CFG_W'(250);

  typedef enum logic [MODE_W-1:0] {
    MODE_GROUND  = MODE_W'(0),
    MODE_READY   = MODE_W'(1),
    MODE_TAKEOFF = MODE_W'(2),
    MODE_HOLD    = MODE_W'(3),
    MODE_LANDING = MODE_W'(4),
    MODE_STOP    = MODE_W'(5)
  } acc_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_PERIOD = CFG_IDX_W'(0),
    REG_GROUND_WAIT = CFG_IDX_W'(1),
    REG_READY_WAIT  = CFG_IDX_W'(2),
    REG_HOVER       = CFG_IDX_W'(3)
  } acc_reg_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } acc_alu_op_t;

  typedef struct packed {
    logic [CFG_W-1:0] tick_period;
    logic [CFG_W-1:0] ground_wait;
    logic [CFG_W-1:0] ready_wait;
    logic [CFG_W-1:0] hover;
  } acc_cfg_t;

  typedef struct packed {
    acc_mode_t mode;
    logic      pulse;
    data_t     target;
    data_t     request;
  } acc_seq_t;

  typedef struct packed {
    logic             start;
    acc_alu_op_t      op;
    wide_t            operand;
    logic [CFG_W-1:0] mult;
    logic [DIV_W-1:0] divisor;
  } acc_alu_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    wide_t result;
  } acc_alu_rsp_t;

  function automatic wide_t sext(input data_t x);
    return wide_t'(x);
  endfunction

  function automatic wide_t clamp(input wide_t x, input wide_t lo, input wide_t hi);
    wide_t r;
    r = x;
    if (x < lo) r = lo;
    else if (x > hi) r = hi;
    return r;
  endfunction

endpackage

/* rtl/core/acc_ifs.sv */
// Valid/ready channel interfaces of the altitude cascade controller:
// measurement input, result output and configuration writes. Uses acc_pkg.
interface acc_in_if;
  logic                valid;
  logic                ready;
  acc_pkg::data_t      meas_speed;
  acc_pkg::data_t      meas_height;
  acc_pkg::data_t      meas_accel;

  modport source (output valid, output meas_speed, output meas_height,
                  output meas_accel, input ready);
  modport sink   (input valid, input meas_speed, input meas_height,
                  input meas_accel, output ready);
endinterface

interface acc_out_if;
  logic                              valid;
  logic                              ready;
  logic [acc_pkg::THR_W-1:0]         throttle;
  logic [acc_pkg::MODE_W-1:0]        flight_mode;
  logic                              estimator_reset;

  modport source (output valid, output throttle, output flight_mode,
                  output estimator_reset, input ready);
  modport sink   (input valid, input throttle, input flight_mode,
                  input estimator_reset, output ready);
endinterface

interface acc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [acc_pkg::CFG_IDX_W-1:0]     index;
  logic [acc_pkg::CFG_W-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/acc_alu.sv */
// Shared iterative arithmetic unit: signed x unsigned shift-add multiply and
// floor division by a small constant divisor. Depends on acc_pkg.
module acc_alu (
  input  logic                  clk,
  input  logic                  rst,
  input  acc_pkg::acc_alu_req_t req,
  output acc_pkg::acc_alu_rsp_t rsp
);

  logic                              busy;
  logic                              done;
  logic [acc_pkg::STEP_CNT_W-1:0]    cnt;
  acc_pkg::acc_alu_op_t              op;
  acc_pkg::wide_t                    sh;
  acc_pkg::wide_t                    acc;
  acc_pkg::wide_t                    mcand;
  logic [acc_pkg::CFG_W-1:0]         mplier;
  logic [acc_pkg::DIV_W-1:0]         rem;
  logic [acc_pkg::DIV_W-1:0]         divisor;
  logic                              neg;

  acc_pkg::wide_t                    mul_next;
  acc_pkg::wide_t                    div_q;
  logic [acc_pkg::DIV_W-1:0]         div_rem;
  logic [acc_pkg::DIV_W:0]           trial;

  // restoring division on the magnitude, DIV_BITS quotient bits per cycle;
  // remainder stays below the divisor so the trial word is narrow
  always_comb begin
    mul_next = (acc <<< 1) + (mplier[acc_pkg::CFG_W-1] ? mcand : '0);
    div_q    = sh;
    div_rem  = rem;
    trial    = '0;
    for (int k = 0; k < acc_pkg::DIV_BITS; k++) begin
      trial = {div_rem, div_q[acc_pkg::WIDE_W-1]};
      div_q = div_q << 1;
      if (trial >= {1'b0, divisor}) begin
        trial    = trial - {1'b0, divisor};
        div_q[0] = 1'b1;
      end
      div_rem = trial[acc_pkg::DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.op == acc_pkg::ALU_MUL) ? acc_pkg::STEP_CNT_W'(acc_pkg::MUL_STEPS)
                                             : acc_pkg::STEP_CNT_W'(acc_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == acc_pkg::STEP_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // floor(x/d) for negative x is ~(~x / d)
  always_ff @(posedge clk) begin
    if (req.start) begin
      op      <= req.op;
      mcand   <= req.operand;
      mplier  <= req.mult;
      acc     <= '0;
      neg     <= req.operand[acc_pkg::WIDE_W-1];
      sh      <= req.operand[acc_pkg::WIDE_W-1] ? ~req.operand : req.operand;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      if (op == acc_pkg::ALU_MUL) begin
        acc    <= mul_next;
        mplier <= mplier << 1;
      end else begin
        sh  <= div_q;
        rem <= div_rem;
      end
    end
  end

  always_comb begin
    rsp.busy   = busy;
    rsp.done   = done;
    rsp.result = (op == acc_pkg::ALU_MUL) ? acc : (neg ? ~sh : sh);
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("alu started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("alu done while still busy");
  a_busy_ends: assert property (@(posedge clk) disable iff (rst)
    (busy && !done) |=> (busy || done)) else $error("alu dropped busy without done");
`endif

endmodule

/* rtl/core/acc_seq.sv */
// Mission sequencer: flight mode, saturating tick counters, target height,
// previous height and the take-off pulse. Depends on acc_pkg.
module acc_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              strobe,
  input  acc_pkg::data_t    height,
  input  acc_pkg::acc_cfg_t cfg,
  output acc_pkg::acc_seq_t seq
);

  acc_pkg::acc_mode_t               mode;
  acc_pkg::acc_mode_t               mode_next;
  logic [acc_pkg::COUNT_WIDTH-1:0]  ground_count;
  logic [acc_pkg::COUNT_WIDTH-1:0]  ready_count;
  logic [acc_pkg::COUNT_WIDTH-1:0]  hold_count;
  logic [acc_pkg::COUNT_WIDTH-1:0]  ground_count_next;
  logic [acc_pkg::COUNT_WIDTH-1:0]  ready_count_next;
  logic [acc_pkg::COUNT_WIDTH-1:0]  hold_count_next;
  acc_pkg::data_t                   target;
  acc_pkg::data_t                   target_next;
  acc_pkg::data_t                   previous_height;
  logic                             pulse;
  logic                             pulse_next;
  acc_pkg::wide_t                   prev_w;
  logic                             climbed;
  logic                             landed;

  function automatic logic [acc_pkg::COUNT_WIDTH-1:0] inc_sat(
    input logic [acc_pkg::COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  always_comb begin
    ground_count_next = (mode == acc_pkg::MODE_GROUND) ? inc_sat(ground_count) : ground_count;
    ready_count_next  = (mode == acc_pkg::MODE_READY)  ? inc_sat(ready_count)  : ready_count;
    hold_count_next   = (mode == acc_pkg::MODE_HOLD)   ? inc_sat(hold_count)   : hold_count;

    prev_w  = acc_pkg::sext(previous_height);
    climbed = ((prev_w <<< 2) + prev_w) >= acc_pkg::TAKEOFF_DONE;
    landed  = ((prev_w <<< 4) + (prev_w <<< 2)) <= acc_pkg::LANDED;

    mode_next  = mode;
    pulse_next = 1'b0;
    unique case (mode)
      acc_pkg::MODE_GROUND: begin
        if (acc_pkg::CMP_W'(ground_count_next) >= acc_pkg::CMP_W'(cfg.ground_wait))
          mode_next = acc_pkg::MODE_READY;
      end
      acc_pkg::MODE_READY: begin
        if (acc_pkg::CMP_W'(ready_count_next) >= acc_pkg::CMP_W'(cfg.ready_wait)) begin
          mode_next  = acc_pkg::MODE_TAKEOFF;
          pulse_next = 1'b1;
        end
      end
      acc_pkg::MODE_TAKEOFF: begin
        if (climbed) mode_next = acc_pkg::MODE_HOLD;
      end
      acc_pkg::MODE_HOLD: begin
        if (acc_pkg::CMP_W'(hold_count_next) > acc_pkg::CMP_W'(cfg.hover))
          mode_next = acc_pkg::MODE_LANDING;
      end
      acc_pkg::MODE_LANDING: begin
        if (landed) mode_next = acc_pkg::MODE_STOP;
      end
      acc_pkg::MODE_STOP: begin
        mode_next = acc_pkg::MODE_STOP;
      end
      default: mode_next = mode;
    endcase

    // ground, ready and stop keep the last target
    target_next = target;
    if (mode_next == acc_pkg::MODE_TAKEOFF || mode_next == acc_pkg::MODE_HOLD)
      target_next = acc_pkg::HOLD_HEIGHT;
    else if (mode_next == acc_pkg::MODE_LANDING)
      target_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= acc_pkg::MODE_GROUND;
      ground_count    <= '0;
      ready_count     <= '0;
      hold_count      <= '0;
      target          <= '0;
      previous_height <= '0;
      pulse           <= 1'b0;
    end else if (strobe) begin
      mode            <= mode_next;
      ground_count    <= ground_count_next;
      ready_count     <= ready_count_next;
      hold_count      <= hold_count_next;
      target          <= target_next;
      previous_height <= height;
      pulse           <= pulse_next;
    end
  end

  always_comb begin
    seq.mode   = mode;
    seq.pulse  = pulse;
    seq.target = target;
    unique case (mode)
      acc_pkg::MODE_TAKEOFF: seq.request = acc_pkg::VEL_TAKEOFF;
      acc_pkg::MODE_LANDING: seq.request = acc_pkg::VEL_LANDING;
      default:               seq.request = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_pulse_mode: assert property (@(posedge clk) disable iff (rst)
    pulse |-> mode == acc_pkg::MODE_TAKEOFF) else $error("pulse outside take-off");
  a_stop_final: assert property (@(posedge clk) disable iff (rst)
    mode == acc_pkg::MODE_STOP |=> mode == acc_pkg::MODE_STOP)
    else $error("left stop mode");
  a_mode_hold: assert property (@(posedge clk) disable iff (rst)
    !strobe |=> $stable(mode)) else $error("mode moved without a tick");
`endif

endmodule

/* rtl/core/altitude_cascade_controller.sv */
// Altitude cascade controller. Each input transfer is one control tick; it
// yields one result transfer (throttle, flight mode, estimator reset pulse).
// The input is ready again in the same cycle that the result turns valid, so
// a new tick is taken only once the block is through with the last one. The
// work of a tick is five passes through the single shared multiply/divide
// unit (16 iterations each, plus a load step and a collect step per pass):
// the low-pass divide by 5, the acceleration divide by 20, the error by tick
// period product and the two divides by 5 of the integral and output paths.
// Six further steps (ramp limit, ramp update, height error, velocity sum,
// expected acceleration, hand-off) complete it. If the output register still
// holds an untaken result, the tick waits in its last step and the input
// stays not ready until that result transfers. A finished result waits in
// the output register while the next tick is taken in. Configuration writes
// are accepted in any cycle and should be issued while no tick is in flight.
// Depends on acc_pkg, acc_ifs, acc_seq and acc_alu.
module altitude_cascade_controller (
  input  logic            clk,
  input  logic            rst,
  acc_in_if.sink          in_ch,
  acc_out_if.source       out_ch,
  acc_cfg_if.sink         cfg
);

  localparam int CTL_N = 17;

  typedef enum logic [CTL_N-1:0] {
    S_IDLE    = CTL_N'(1) << 0,
    S_LIMIT   = CTL_N'(1) << 1,
    S_RAMP    = CTL_N'(1) << 2,
    S_LPF     = CTL_N'(1) << 3,
    S_LPF_W   = CTL_N'(1) << 4,
    S_ACC20   = CTL_N'(1) << 5,
    S_ACC20_W = CTL_N'(1) << 6,
    S_HERR    = CTL_N'(1) << 7,
    S_VSUM    = CTL_N'(1) << 8,
    S_EXPA    = CTL_N'(1) << 9,
    S_MUL     = CTL_N'(1) << 10,
    S_MUL_W   = CTL_N'(1) << 11,
    S_INC     = CTL_N'(1) << 12,
    S_INC_W   = CTL_N'(1) << 13,
    S_WZ      = CTL_N'(1) << 14,
    S_WZ_W    = CTL_N'(1) << 15,
    S_DONE    = CTL_N'(1) << 16
  } ctl_state_t;

  ctl_state_t                        state;
  ctl_state_t                        state_next;
  acc_pkg::acc_cfg_t                 cfg_regs;
  acc_pkg::acc_seq_t                 seq;
  acc_pkg::acc_alu_req_t             alu_req;
  acc_pkg::acc_alu_rsp_t             alu_rsp;

  logic                              accept;
  logic                              out_free;

  acc_pkg::data_t                    speed;
  acc_pkg::data_t                    height;
  acc_pkg::data_t                    accel;
  acc_pkg::data_t                    ramp_velocity;
  acc_pkg::data_t                    filtered_velocity;
  logic signed [acc_pkg::INTEG_W-1:0] accel_integral;
  logic [acc_pkg::LIM_W-1:0]         lim;
  acc_pkg::wide_t                    work;
  acc_pkg::wide_t                    exp_acc;
  acc_pkg::wide_t                    aux;
  logic [acc_pkg::THR_W-1:0]         throttle;

  logic                              out_valid;
  logic [acc_pkg::THR_W-1:0]         out_throttle;
  acc_pkg::acc_mode_t                out_mode;
  logic                              out_pulse;

  logic [acc_pkg::LIM_W-1:0]         lim_calc;
  acc_pkg::wide_t                    lim_w;
  acc_pkg::wide_t                    ramp_sum;
  acc_pkg::wide_t                    hei_err;
  acc_pkg::wide_t                    prod_floor;
  acc_pkg::wide_t                    integ_sum;
  acc_pkg::wide_t                    wz;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == S_IDLE);
  assign out_free     = !out_valid || out_ch.ready;
  assign cfg.ready    = 1'b1;

  assign out_ch.valid           = out_valid;
  assign out_ch.throttle        = out_throttle;
  assign out_ch.flight_mode     = out_mode;
  assign out_ch.estimator_reset = out_pulse;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.tick_period <= acc_pkg::TICK_PERIOD_RST;
      cfg_regs.ground_wait <= acc_pkg::GROUND_WAIT_RST;
      cfg_regs.ready_wait  <= acc_pkg::READY_WAIT_RST;
      cfg_regs.hover       <= acc_pkg::HOVER_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        acc_pkg::REG_TICK_PERIOD: cfg_regs.tick_period <= cfg.data;
        acc_pkg::REG_GROUND_WAIT: cfg_regs.ground_wait <= cfg.data;
        acc_pkg::REG_READY_WAIT:  cfg_regs.ready_wait  <= cfg.data;
        acc_pkg::REG_HOVER:       cfg_regs.hover       <= cfg.data;
        default: ;
      endcase
    end
  end

  acc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .strobe (accept),
    .height (in_ch.meas_height),
    .cfg    (cfg_regs),
    .seq    (seq)
  );

  acc_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    alu_req.start   = 1'b0;
    alu_req.op      = acc_pkg::ALU_DIV;
    alu_req.operand = '0;
    alu_req.mult    = cfg_regs.tick_period;
    alu_req.divisor = acc_pkg::DIV_FIVE;
    unique case (state)
      S_LPF: begin
        alu_req.start   = 1'b1;
        alu_req.operand = acc_pkg::sext(ramp_velocity) - acc_pkg::sext(filtered_velocity);
      end
      S_ACC20: begin
        alu_req.start   = 1'b1;
        alu_req.operand = acc_pkg::sext(accel);
        alu_req.divisor = acc_pkg::DIV_TWENTY;
      end
      S_MUL: begin
        alu_req.start   = 1'b1;
        alu_req.op      = acc_pkg::ALU_MUL;
        alu_req.operand = exp_acc - acc_pkg::sext(accel);
      end
      S_INC: begin
        alu_req.start   = 1'b1;
        alu_req.operand = work;
      end
      S_WZ: begin
        alu_req.start   = 1'b1;
        alu_req.operand = exp_acc <<< 1;
      end
      default: ;
    endcase
  end

  always_comb begin
    // 500 = 512 - 8 - 4
    lim_calc   = (acc_pkg::LIM_W'(cfg_regs.tick_period) << 9)
               - (acc_pkg::LIM_W'(cfg_regs.tick_period) << 3)
               - (acc_pkg::LIM_W'(cfg_regs.tick_period) << 2);
    lim_w      = acc_pkg::wide_t'(lim);
    ramp_sum   = acc_pkg::clamp(work, -lim_w, lim_w) + acc_pkg::sext(ramp_velocity);
    hei_err    = acc_pkg::sext(seq.target) - acc_pkg::sext(height);
    prod_floor = alu_rsp.result >>> acc_pkg::FRAC_BITS;
    integ_sum  = acc_pkg::clamp(acc_pkg::wide_t'(accel_integral) + alu_rsp.result,
                                '0, acc_pkg::INTEG_MAX);
    wz         = acc_pkg::clamp(alu_rsp.result + acc_pkg::wide_t'(accel_integral),
                                '0, acc_pkg::THR_MAX);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept) state_next = S_LIMIT;
      S_LIMIT:   state_next = S_RAMP;
      S_RAMP:    state_next = S_LPF;
      S_LPF:     state_next = S_LPF_W;
      S_LPF_W:   if (alu_rsp.done) state_next = S_ACC20;
      S_ACC20:   state_next = S_ACC20_W;
      S_ACC20_W: if (alu_rsp.done) state_next = S_HERR;
      S_HERR:    state_next = S_VSUM;
      S_VSUM:    state_next = S_EXPA;
      S_EXPA:    state_next = S_MUL;
      S_MUL:     state_next = S_MUL_W;
      S_MUL_W:   if (alu_rsp.done) state_next = S_INC;
      S_INC:     state_next = S_INC_W;
      S_INC_W:   if (alu_rsp.done) state_next = S_WZ;
      S_WZ:      state_next = S_WZ_W;
      S_WZ_W:    if (alu_rsp.done) state_next = S_DONE;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      ramp_velocity     <= '0;
      filtered_velocity <= '0;
      accel_integral    <= '0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      if (state == S_RAMP)
        ramp_velocity <= acc_pkg::data_t'(ramp_sum);
      if (state == S_LPF_W && alu_rsp.done)
        filtered_velocity <= acc_pkg::data_t'(acc_pkg::sext(filtered_velocity)
                                              + alu_rsp.result);
      if (state == S_INC_W && alu_rsp.done)
        accel_integral <= acc_pkg::INTEG_W'(integ_sum);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      speed  <= in_ch.meas_speed;
      height <= in_ch.meas_height;
      accel  <= in_ch.meas_accel;
    end
    if (state == S_LIMIT) begin
      work <= acc_pkg::sext(seq.request) - acc_pkg::sext(ramp_velocity);
      lim  <= lim_calc;
    end
    if (state == S_ACC20_W && alu_rsp.done) aux <= alu_rsp.result;
    // 100 = 64 + 32 + 4
    if (state == S_HERR) work <= (hei_err <<< 6) + (hei_err <<< 5) + (hei_err <<< 2);
    if (state == S_VSUM)
      work <= work + acc_pkg::sext(filtered_velocity) - acc_pkg::sext(speed) - aux;
    if (state == S_EXPA) exp_acc <= (work <<< 2) + work;
    // floor shift of the product, then times three
    if (state == S_MUL_W && alu_rsp.done) work <= prod_floor + (prod_floor <<< 1);
    if (state == S_WZ_W && alu_rsp.done) throttle <= wz[acc_pkg::FRAC_BITS +: acc_pkg::THR_W];
    if (state == S_DONE && out_free) begin
      out_throttle <= throttle;
      out_mode     <= seq.mode;
      out_pulse    <= seq.pulse;
    end
  end

`ifndef SYNTHESIS
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_LIMIT) else $error("tick transfer did not start the sequence");
  a_thr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_throttle <= acc_pkg::THR_MAX_INT) else $error("throttle above limit");
  a_pulse_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_pulse) |-> out_mode == acc_pkg::MODE_TAKEOFF)
    else $error("estimator reset outside take-off");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for altitude_cascade_controller: walks one mission from ground to stop
// with random measurements, predicts every command and compares it. Needs acc_pkg and acc_ifs.
module testbench;

  localparam int     CYCLE_LIMIT = 1_000_000;
  localparam longint Q_ONE       = longint'(1) << acc_pkg::FRAC_BITS;
  // lowest height that ends take-off, highest that ends landing
  localparam acc_pkg::data_t HOLD_ENTRY_H = acc_pkg::data_t'((4 * Q_ONE + 4) / 5);
  localparam acc_pkg::data_t LANDED_H     = acc_pkg::data_t'((3 * Q_ONE) / 20);
  localparam acc_pkg::data_t S_MAX        = 32'sh7FFF_FFFF;
  localparam acc_pkg::data_t S_MIN        = 32'sh8000_0000;
  localparam logic [acc_pkg::COUNT_WIDTH-1:0] COUNT_TOP = '1;
  // indexes past the register map; low bits alias real registers
  localparam logic [acc_pkg::CFG_IDX_W-1:0] IDX_ALIAS_TICK   = acc_pkg::CFG_IDX_W'(4);
  localparam logic [acc_pkg::CFG_IDX_W-1:0] IDX_ALIAS_GROUND = acc_pkg::CFG_IDX_W'(5);
  localparam logic [acc_pkg::CFG_IDX_W-1:0] IDX_ALIAS_READY  = acc_pkg::CFG_IDX_W'(6);
  localparam logic [acc_pkg::CFG_IDX_W-1:0] IDX_TOP          = '1;

  typedef struct {
    logic [acc_pkg::THR_W-1:0] throttle;
    acc_pkg::acc_mode_t        mode;
    logic                      est_reset;
  } cmd_t;

  logic clk = 1'b0;
  logic rst;

  acc_in_if  in_ch ();
  acc_out_if out_ch ();
  acc_cfg_if cfg_ch ();

  altitude_cascade_controller dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  // controller model state and register copy
  acc_pkg::acc_mode_t              mission_mode;
  logic [acc_pkg::COUNT_WIDTH-1:0] gnd_ticks, rdy_ticks, hold_ticks;
  longint                          ramp_vel, filt_vel, integ_acc, target_h, prev_h;
  logic [acc_pkg::CFG_W-1:0]       period_q, gnd_wait, rdy_wait, hover_wait;

  cmd_t predicted_cmds[$];
  int   tx_idle_pct, rx_idle_pct, rx_hold_off;
  int   n_errors, ticks_sent, results_checked, reg_writes, cycle_count;
  int   mode_hits[6];

  function automatic longint floor_div(input longint x, input longint d);
    longint q;
    q = x / d;
    if (x % d != 0 && x < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint bound(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic void predict_command(input acc_pkg::data_t spd, input acc_pkg::data_t hgt,
                                          input acc_pkg::data_t acc);
    longint speed, height, accel, dt, request, lim, hei_err, vel_err, exp_acc, acc_err;
    longint incr, wz;
    cmd_t   c;
    speed = spd;
    height = hgt;
    accel = acc;
    dt = longint'(period_q);
    c.est_reset = 1'b0;

    if (mission_mode == acc_pkg::MODE_GROUND && gnd_ticks != COUNT_TOP)
      gnd_ticks = gnd_ticks + 1'b1;
    if (mission_mode == acc_pkg::MODE_READY && rdy_ticks != COUNT_TOP)
      rdy_ticks = rdy_ticks + 1'b1;
    if (mission_mode == acc_pkg::MODE_HOLD && hold_ticks != COUNT_TOP)
      hold_ticks = hold_ticks + 1'b1;

    // sequencer decides on last tick's height
    if (mission_mode == acc_pkg::MODE_GROUND && gnd_ticks >= gnd_wait) begin
      mission_mode = acc_pkg::MODE_READY;
    end else if (mission_mode == acc_pkg::MODE_READY && rdy_ticks >= rdy_wait) begin
      mission_mode = acc_pkg::MODE_TAKEOFF;
      c.est_reset = 1'b1;
    end else if (mission_mode == acc_pkg::MODE_TAKEOFF && 5 * prev_h >= 4 * Q_ONE) begin
      mission_mode = acc_pkg::MODE_HOLD;
    end else if (mission_mode == acc_pkg::MODE_HOLD && hold_ticks > hover_wait) begin
      mission_mode = acc_pkg::MODE_LANDING;
    end else if (mission_mode == acc_pkg::MODE_LANDING && 20 * prev_h <= 3 * Q_ONE) begin
      mission_mode = acc_pkg::MODE_STOP;
    end

    request = 0;
    case (mission_mode)
      acc_pkg::MODE_TAKEOFF: begin
        request = 60 * Q_ONE;
        target_h = Q_ONE;
      end
      acc_pkg::MODE_HOLD: target_h = Q_ONE;
      acc_pkg::MODE_LANDING: begin
        request = -45 * Q_ONE;
        target_h = 0;
      end
      default: ;
    endcase

    lim = 500 * dt;
    ramp_vel = ramp_vel + bound(request - ramp_vel, -lim, lim);
    filt_vel = filt_vel + floor_div(ramp_vel - filt_vel, 5);

    hei_err = target_h - height;
    vel_err = 100 * hei_err + filt_vel - speed - floor_div(accel, 20);
    exp_acc = 5 * vel_err;
    acc_err = exp_acc - accel;
    incr = floor_div(((acc_err * dt) >>> acc_pkg::FRAC_BITS) * 3, 5);
    integ_acc = bound(integ_acc + incr, 0, 600 * Q_ONE);
    wz = bound(floor_div(exp_acc * 2, 5) + integ_acc, 0, 900 * Q_ONE);
    prev_h = height;

    c.throttle = acc_pkg::THR_W'(wz >>> acc_pkg::FRAC_BITS);
    c.mode = mission_mode;
    predicted_cmds.push_back(c);
  endfunction

  task automatic report_error(input string what);
    if (n_errors < 50) $display("ERROR at %0t ns: %s", $time, what);
    n_errors++;
  endtask

  // valid stays high across back-to-back transfers; lowered only to idle
  task automatic send_tick(input acc_pkg::data_t spd, input acc_pkg::data_t hgt,
                           input acc_pkg::data_t acc);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.meas_speed  <= spd;
    in_ch.meas_height <= hgt;
    in_ch.meas_accel  <= acc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_command(spd, hgt, acc);
    ticks_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (predicted_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [acc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [acc_pkg::CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      acc_pkg::REG_TICK_PERIOD: period_q = val;
      acc_pkg::REG_GROUND_WAIT: gnd_wait = val;
      acc_pkg::REG_READY_WAIT:  rdy_wait = val;
      acc_pkg::REG_HOVER:       hover_wait = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic end_writes();
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic acc_pkg::data_t rand_signal();
    if ($urandom_range(1)) return acc_pkg::data_t'($urandom);
    return acc_pkg::data_t'($urandom_range(0, 400 * 65536)) - acc_pkg::data_t'(200 * 65536);
  endfunction

  // result side: checks each transfer, then decides ready for the next cycle
  always @(posedge clk) begin : result_side
    cmd_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (predicted_cmds.size() == 0) begin
        report_error($sformatf("unexpected result throttle %0d mode %0d",
                               out_ch.throttle, out_ch.flight_mode));
      end else begin
        want = predicted_cmds.pop_front();
        mode_hits[int'(want.mode)]++;
        if (out_ch.throttle !== want.throttle)
          report_error($sformatf("result %0d: throttle %0d, want %0d",
                                 results_checked, out_ch.throttle, want.throttle));
        if (out_ch.flight_mode !== want.mode)
          report_error($sformatf("result %0d: flight_mode %0d, want %s",
                                 results_checked, out_ch.flight_mode, want.mode.name()));
        if (out_ch.estimator_reset !== want.est_reset)
          report_error($sformatf("result %0d: estimator_reset %b, want %b",
                                 results_checked, out_ch.estimator_reset, want.est_reset));
        results_checked++;
      end
    end
    if (rx_hold_off > 0) rx_hold_off = rx_hold_off - 1;
    out_ch.ready <= (rx_hold_off == 0) && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, predicted_cmds.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // unused indexes must not touch any register; the extremes then run on defaults
  task automatic test_extremes_on_ground();
    write_reg(IDX_ALIAS_TICK, '0);
    write_reg(IDX_ALIAS_GROUND, '0);
    write_reg(IDX_ALIAS_READY, '0);
    write_reg(IDX_TOP, '1);
    end_writes();
    send_tick(0, 0, 0);
    send_tick(S_MAX, S_MAX, S_MAX);
    send_tick(S_MIN, S_MIN, S_MIN);
    send_tick(S_MAX, S_MIN, 0);
    send_tick(S_MIN, S_MAX, -1);
    send_tick(0, 0, S_MAX);
    send_tick(0, 0, S_MIN);
    send_tick(-1, 1, -1);
    send_tick(1, -1, 1);
    send_tick(0, HOLD_ENTRY_H, 0);
    send_tick(0, LANDED_H, 0);
    send_tick(acc_pkg::data_t'(200 * Q_ONE), acc_pkg::data_t'(-Q_ONE),
              acc_pkg::data_t'(20 * Q_ONE));
    drain_results();
  endtask

  task automatic test_ground_wait();
    write_reg(acc_pkg::REG_TICK_PERIOD, '1);
    write_reg(acc_pkg::REG_GROUND_WAIT, '1);
    end_writes();
    repeat (90) send_tick(rand_signal(), rand_signal(), rand_signal());
    drain_results();
  endtask

  // long receiver hold-off while ticks keep coming, so the input backs up
  task automatic test_ready_backpressure();
    write_reg(acc_pkg::REG_GROUND_WAIT, '0);
    write_reg(acc_pkg::REG_READY_WAIT, '1);
    write_reg(acc_pkg::REG_TICK_PERIOD, acc_pkg::CFG_W'(1));
    end_writes();
    rx_hold_off = 600;
    repeat (100) send_tick(rand_signal(), rand_signal(), rand_signal());
    drain_results();
  endtask

  task automatic test_takeoff();
    acc_pkg::data_t h;
    write_reg(acc_pkg::REG_READY_WAIT, '0);
    write_reg(acc_pkg::REG_TICK_PERIOD, acc_pkg::TICK_PERIOD_RST);
    end_writes();
    repeat (200) begin
      case ($urandom_range(3))
        0, 1: h = acc_pkg::data_t'($urandom_range(0, 52428 + 131072))
                  - acc_pkg::data_t'(131072);
        2: h = acc_pkg::data_t'($urandom | 32'h8000_0000);
        default: h = $urandom_range(1) ? HOLD_ENTRY_H - 1 : acc_pkg::data_t'(0);
      endcase
      send_tick(rand_signal(), h, rand_signal());
    end
    h = $urandom_range(1) ? HOLD_ENTRY_H
                          : acc_pkg::data_t'($urandom_range(52429, 32'h7FFF_FFFF));
    send_tick(rand_signal(), h, rand_signal());
    drain_results();
  endtask

  // zero period freezes ramp and integral; a run of twelve ticks early in the loop waits out each result
  task automatic test_hold_zero_period();
    acc_pkg::data_t h;
    write_reg(acc_pkg::REG_TICK_PERIOD, '0);
    write_reg(acc_pkg::REG_HOVER, '1);
    end_writes();
    repeat (152) begin
      if ($urandom_range(1))
        h = acc_pkg::data_t'($urandom_range(0, 4 * 65536));
      else
        h = acc_pkg::data_t'($urandom);
      send_tick(rand_signal(), h, rand_signal());
      if (ticks_sent % 152 >= 140) drain_results();
    end
    drain_results();
  endtask

  task automatic test_landing();
    acc_pkg::data_t h;
    write_reg(acc_pkg::REG_HOVER, '0);
    write_reg(acc_pkg::REG_TICK_PERIOD, '1);
    end_writes();
    repeat (200) begin
      case ($urandom_range(3))
        0, 1: h = acc_pkg::data_t'($urandom_range(LANDED_H + 1, 4 * 65536));
        2: begin
          h = acc_pkg::data_t'($urandom & 32'h7FFF_FFFF);
          if (h <= LANDED_H) h = LANDED_H + 1;
        end
        default: h = LANDED_H + 1;
      endcase
      send_tick(rand_signal(), h, rand_signal());
    end
    h = $urandom_range(1) ? LANDED_H : acc_pkg::data_t'($urandom | 32'h8000_0000);
    send_tick(rand_signal(), h, rand_signal());
    drain_results();
  endtask

  // stop is terminal whatever the registers say
  task automatic test_stop_terminal();
    write_reg(acc_pkg::REG_TICK_PERIOD, acc_pkg::CFG_W'($urandom_range(1, 65535)));
    write_reg(acc_pkg::REG_GROUND_WAIT, acc_pkg::CFG_W'($urandom));
    write_reg(acc_pkg::REG_READY_WAIT, acc_pkg::CFG_W'($urandom));
    write_reg(acc_pkg::REG_HOVER, acc_pkg::CFG_W'($urandom));
    end_writes();
    repeat (180) send_tick(rand_signal(), rand_signal(), rand_signal());
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.meas_speed = '0;
    in_ch.meas_height = '0;
    in_ch.meas_accel = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    mission_mode = acc_pkg::MODE_GROUND;
    gnd_ticks = '0;
    rdy_ticks = '0;
    hold_ticks = '0;
    ramp_vel = 0;
    filt_vel = 0;
    integ_acc = 0;
    target_h = 0;
    prev_h = 0;
    period_q = acc_pkg::TICK_PERIOD_RST;
    gnd_wait = acc_pkg::GROUND_WAIT_RST;
    rdy_wait = acc_pkg::READY_WAIT_RST;
    hover_wait = acc_pkg::HOVER_RST;
    rx_hold_off = 0;
    tx_idle_pct = 15;
    rx_idle_pct = 71;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes_on_ground();
    test_ground_wait();
    test_ready_backpressure();
    tx_idle_pct = 71;
    rx_idle_pct = 15;
    test_takeoff();
    test_hold_zero_period();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_landing();
    test_stop_terminal();

    repeat (200) @(posedge clk);
    $display("Summary: %0d ticks sent, %0d commands checked, %0d register writes",
             ticks_sent, results_checked, reg_writes);
    $display("Summary: per mode ground %0d ready %0d takeoff %0d hold %0d landing %0d stop %0d",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4],
             mode_hits[5]);
    if (n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
